// ===== src/pwlt_pkg.sv =====
package pwlt_pkg;

  localparam int SEGMENTS  = 20;
  localparam int SEG_IDX_W = 5;
  localparam int R_W       = 20;
  localparam int DR_W      = 18;
  localparam int P_W       = 24;
  localparam int CNT_W     = 5;
  localparam int T_W       = 9;
  localparam int Q_USE_W   = 8;

  localparam logic [R_W-1:0] R_ABOVE_LIMIT = 20'd329927;
  localparam logic signed [T_W-1:0] BELOW_TEMP = 9'sd160;

  localparam logic [R_W-1:0] R_HIGH [SEGMENTS] = '{
    20'd329927, 20'd173153, 20'd95009, 20'd54247, 20'd32101,
    20'd19621,  20'd12351,  20'd9900,  20'd7952,  20'd5227,
    20'd3517,   20'd2418,   20'd1695,  20'd1211,  20'd881,
    20'd651,    20'd488,    20'd372,   20'd306,   20'd237
  };

  localparam logic [R_W-1:0] R_LOW [SEGMENTS] = '{
    20'd173153, 20'd95009,  20'd54247, 20'd32101, 20'd19621,
    20'd12351,  20'd9900,   20'd7952,  20'd5227,  20'd3517,
    20'd2418,   20'd1695,   20'd1211,  20'd881,   20'd651,
    20'd488,    20'd372,    20'd306,   20'd237,   20'd153
  };

  localparam logic signed [T_W-1:0] T_HIGH [SEGMENTS] = '{
    -9'sd30, -9'sd20, -9'sd10, 9'sd0,   9'sd10,
    9'sd20,  9'sd25,  9'sd30,  9'sd40,  9'sd50,
    9'sd60,  9'sd70,  9'sd80,  9'sd90,  9'sd100,
    9'sd110, 9'sd120, 9'sd130, 9'sd140, 9'sd150
  };

  localparam bit DT_TEN [SEGMENTS] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };

  typedef enum logic [1:0] {
    STATUS_IN_RANGE = 2'd0,
    STATUS_ABOVE    = 2'd1,
    STATUS_BELOW    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic                 hit;
    logic [SEG_IDX_W-1:0] idx;
    status_t              status;
  } seg_info_t;

endpackage

// ===== src/pwlt_seg_search.sv =====
module pwlt_seg_search
  import pwlt_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic [R_W-1:0]   resistance,
  output seg_info_t        info
);

  seg_info_t info_next;

  always_comb begin
    info_next.hit    = 1'b0;
    info_next.idx    = '0;
    for (int i = SEGMENTS - 1; i >= 0; i--) begin
      if (resistance >= R_LOW[i]) begin
        info_next.hit = 1'b1;
        info_next.idx = SEG_IDX_W'(i);
      end
    end
    priority if (resistance > R_ABOVE_LIMIT) begin
      info_next.status = STATUS_ABOVE;
    end else if (!info_next.hit) begin
      info_next.status = STATUS_BELOW;
    end else begin
      info_next.status = STATUS_IN_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      info <= info_next;
    end
  end

endmodule

// ===== src/pwlt_div.sv =====
module pwlt_div
  import pwlt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [P_W-1:0]  dividend,
  input  logic [DR_W-1:0] divisor,
  output logic            done,
  output logic [P_W-1:0]  quotient,
  output logic [DR_W-1:0] remainder
);

  logic [DR_W-1:0]  dsr;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DR_W:0]    shifted;
  logic [DR_W+1:0]  trial;

  assign shifted = {remainder, quotient[P_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(P_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr       <= divisor;
      remainder <= '0;
      quotient  <= dividend;
    end else if (running) begin
      if (!trial[DR_W+1]) begin
        remainder <= trial[DR_W-1:0];
        quotient  <= {quotient[P_W-2:0], 1'b1};
      end else begin
        remainder <= shifted[DR_W-1:0];
        quotient  <= {quotient[P_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/thermistor_piecewise_linear_temperature.sv =====
// Converts an NTC thermistor resistance in ohms to whole degrees Celsius by
// linear interpolation over a fixed 20-segment table, with a range status.
// Raise start with resistance_ohms while busy is low; the result appears on
// temperature_c and range_status for exactly one cycle with valid high, and
// must be captured then since it cannot be held off. An in-table or
// above-table reading passes from acceptance through the prep state and
// the 24-step restoring divider, which forms the interpolation quotient
// one bit per cycle; a reading below the table skips the divider. busy
// drops in the cycle valid is shown, so the next reading may be started then.
module thermistor_piecewise_linear_temperature
  import pwlt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [19:0]           resistance_ohms,
  output logic                  busy,
  output logic                  valid,
  output logic signed [8:0]     temperature_c,
  output logic [1:0]            range_status
);

  state_t          state;
  state_t          state_next;
  logic            accept;
  logic [R_W-1:0]  r_hold;
  seg_info_t       seg;
  logic            div_start;
  logic            div_done;
  logic [P_W-1:0]  div_quo;
  logic [DR_W-1:0] div_rem;
  logic [R_W-1:0]  d;
  logic [P_W-1:0]  d_x5;
  logic [P_W-1:0]  p;
  logic [R_W-1:0]  dr_full;
  logic            res_load;
  logic signed [T_W-1:0] res_temp;
  logic signed [T_W:0]   t_base;
  logic signed [T_W:0]   t_adj;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  pwlt_seg_search u_seg (
    .clk        (clk),
    .load       (accept),
    .resistance (resistance_ohms),
    .info       (seg)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      r_hold <= resistance_ohms;
    end
  end

  assign d       = r_hold - R_LOW[seg.idx];
  assign d_x5    = {2'b00, d, 2'b00} + {4'b0000, d};
  assign p       = DT_TEN[seg.idx] ? {d_x5[P_W-2:0], 1'b0} : d_x5;
  assign dr_full = R_HIGH[seg.idx] - R_LOW[seg.idx];

  pwlt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (p),
    .divisor   (dr_full[DR_W-1:0]),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign t_base = {T_HIGH[seg.idx][T_W-1], T_HIGH[seg.idx]}
                - $signed({2'b00, div_quo[Q_USE_W-1:0]});
  assign t_adj  = ((div_rem != '0) && (t_base > 0)) ? t_base - 10'sd1 : t_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    res_load   = 1'b0;
    res_temp   = t_adj[T_W-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (seg.hit) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          res_load   = 1'b1;
          res_temp   = BELOW_TEMP;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      temperature_c <= res_temp;
      range_status  <= seg.status;
    end
  end

  a_valid_not_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !valid)
    else $error("accepted transaction did not hold busy");

  a_below_temp: assert property (@(posedge clk) disable iff (rst)
    valid && (range_status == STATUS_BELOW) |-> temperature_c == BELOW_TEMP)
    else $error("below-table transaction with wrong temperature");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide state");

endmodule

// ===== test/testbench.sv =====
module testbench;
  import pwlt_pkg::*;

  typedef struct {
    logic [19:0]        ohms;
    logic signed [8:0]  temp;
    status_t            status;
  } reading_t;

  class temp_scoreboard;
    int seg_r_high [20] = '{
      329927, 173153, 95009, 54247, 32101, 19621, 12351, 9900, 7952, 5227,
      3517, 2418, 1695, 1211, 881, 651, 488, 372, 306, 237
    };
    int seg_r_low [20] = '{
      173153, 95009, 54247, 32101, 19621, 12351, 9900, 7952, 5227, 3517,
      2418, 1695, 1211, 881, 651, 488, 372, 306, 237, 153
    };
    int seg_t_low [20] = '{
      -40, -30, -20, -10, 0, 10, 20, 25, 30, 40,
      50, 60, 70, 80, 90, 100, 110, 120, 130, 140
    };
    int seg_t_high [20] = '{
      -30, -20, -10, 0, 10, 20, 25, 30, 40, 50,
      60, 70, 80, 90, 100, 110, 120, 130, 140, 150
    };

    reading_t expected_q[$];
    int errors;
    int checked;
    int n_in_range;
    int n_above;
    int n_below;

    function int pending();
      return expected_q.size();
    endfunction

    function void note_reading(logic [19:0] ohms);
      reading_t exp_r;
      longint r;
      longint dr;
      longint dt;
      longint num;
      bit hit;
      r = longint'(ohms);
      hit = 1'b0;
      exp_r.ohms = ohms;
      exp_r.temp = 9'sd160;
      for (int i = 0; i < 20; i++) begin
        if (!hit && r >= seg_r_low[i]) begin
          dr = longint'(seg_r_high[i] - seg_r_low[i]);
          dt = longint'(seg_t_high[i] - seg_t_low[i]);
          num = longint'(seg_t_high[i]) * dr - (r - seg_r_low[i]) * dt;
          exp_r.temp = 9'(num / dr);
          hit = 1'b1;
        end
      end
      if (r > seg_r_high[0]) begin
        exp_r.status = STATUS_ABOVE;
        n_above++;
      end else if (r < seg_r_low[19]) begin
        exp_r.status = STATUS_BELOW;
        n_below++;
      end else begin
        exp_r.status = STATUS_IN_RANGE;
        n_in_range++;
      end
      expected_q.push_back(exp_r);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_reading(logic signed [8:0] temp, logic [1:0] status);
      reading_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected transaction temp=%0d status=%0d", temp, status));
      end else begin
        exp_r = expected_q.pop_front();
        checked++;
        if (temp !== exp_r.temp)
          report($sformatf("ohms=%0d temperature_c got %0d want %0d",
                           exp_r.ohms, temp, exp_r.temp));
        if (status !== exp_r.status)
          report($sformatf("ohms=%0d range_status got %0d want %0d",
                           exp_r.ohms, status, exp_r.status));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [19:0]       resistance_ohms = '0;
  logic              busy;
  logic              valid;
  logic signed [8:0] temperature_c;
  logic [1:0]        range_status;

  temp_scoreboard sb = new();

  thermistor_piecewise_linear_temperature uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .resistance_ohms (resistance_ohms),
    .busy            (busy),
    .valid           (valid),
    .temperature_c   (temperature_c),
    .range_status    (range_status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && valid)
      sb.check_reading(temperature_c, range_status);
  end

  task send_reading(logic [19:0] ohms);
    @(negedge clk);
    start <= 1'b1;
    resistance_ohms <= ohms;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_reading(ohms);
  endtask

  task sender_gap(int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
      resistance_ohms <= 20'($urandom);
    end
    if (pct > 0 && $urandom_range(15) == 0) begin
      repeat ($urandom_range(32, 1)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  function logic [19:0] pick_ohms();
    int i;
    int p;
    i = $urandom_range(19);
    case ($urandom_range(9))
      0, 1, 2, 3: return 20'($urandom_range(1048575));
      4, 5, 6, 7: return 20'($urandom_range(sb.seg_r_high[i], sb.seg_r_low[i]));
      8:          return 20'($urandom_range(152));
      default: begin
        p = ($urandom_range(1) == 0) ? sb.seg_r_low[i] : sb.seg_r_high[0];
        return 20'(p + int'($urandom_range(2)) - 1);
      end
    endcase
  endfunction

  int directed_ohms [24] = '{
    0, 1, 152, 153, 154, 236, 237, 238, 306, 372, 1211, 7952,
    9900, 12351, 54247, 95009, 173152, 173153, 329927, 329928,
    524288, 699050, 349525, 1048575
  };
  int pace_pct [4] = '{0, 48, 0, 29};

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed_ohms[k])
      send_reading(20'(directed_ohms[k]));
    for (int ph = 0; ph < 4; ph++) begin
      repeat (420) begin
        sender_gap(pace_pct[ph]);
        send_reading(pick_ohms());
      end
      if (ph == 1) begin
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() > 0) @(negedge clk);
      end
    end
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Checked %0d conversions: %0d in table, %0d above table, %0d below table",
             sb.checked, sb.n_in_range, sb.n_above, sb.n_below);
    $display("Start pacing went through back-to-back, sparse and drained phases");
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
